// ===== rtl/core/mcm_pkg.sv =====
package mcm_pkg;

  localparam int REG_IDX_W = 3;
  localparam int DIV_STEPS = 80;
  localparam int MOD_STEPS = 48;
  localparam int STEP_W = $clog2(DIV_STEPS);

  localparam logic [15:0] ACCENT_K = 16'd36045;
  localparam logic [15:0] BEAT_K   = 16'd11796;
  localparam logic [15:0] DECAY_K  = 16'd65438;
  localparam logic [31:0] LCG_MUL  = 32'd1664525;
  localparam logic [31:0] LCG_ADD  = 32'd1013904223;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_ENABLE     = 3'd0,
    REG_SPR        = 3'd1,
    REG_REF_ROW    = 3'd2,
    REG_REF_SAMPLE = 3'd3,
    REG_BEAT       = 3'd4,
    REG_ACCENT     = 3'd5,
    REG_VOLUME     = 3'd6
  } reg_idx_e;

  typedef struct packed {
    logic signed [15:0] sample_left;
    logic signed [15:0] sample_right;
    logic [47:0]        sample_index;
    logic               resync;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] mixed_left;
    logic signed [15:0] mixed_right;
    logic               click_active;
  } out_word_t;

  typedef struct packed {
    logic [REG_IDX_W-1:0] reg_index;
    logic [47:0]          wdata;
  } cfg_word_t;

  typedef struct packed {
    logic        enable;
    logic [31:0] spr;
    logic [31:0] ref_row;
    logic [47:0] ref_sample;
    logic [7:0]  beat_every;
    logic [7:0]  accent_every;
    logic [15:0] volume;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic div_step;
    logic row_calc;
    logic mod_step;
    logic decide;
    logic seed_step;
    logic mul_step;
    logic mix;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic spr_zero;
  } dp_sts_t;

endpackage

// ===== rtl/core/mcm_stream_if.sv =====
interface mcm_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/mcm_ctrl.sv =====
module mcm_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  mcm_pkg::dp_sts_t sts_i,
  output mcm_pkg::dp_cmd_t cmd_o
);
  import mcm_pkg::*;

  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_DIV    = 9'b000000010,
    ST_ROW    = 9'b000000100,
    ST_MOD    = 9'b000001000,
    ST_DECIDE = 9'b000010000,
    ST_SEED   = 9'b000100000,
    ST_MUL    = 9'b001000000,
    ST_MIX    = 9'b010000000,
    ST_HOLD   = 9'b100000000
  } state_e;

  state_e state_q, state_d;
  logic [STEP_W-1:0] cnt_q, cnt_d;
  logic out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          cnt_d = '0;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (sts_i.spr_zero) begin
          state_d = ST_MIX;
        end else begin
          cmd_o.div_step = 1'b1;
          cnt_d = cnt_q + 1'b1;
          if (cnt_q == STEP_W'(DIV_STEPS - 1)) begin
            cnt_d = '0;
            state_d = ST_ROW;
          end
        end
      end
      ST_ROW: begin
        cmd_o.row_calc = 1'b1;
        state_d = ST_MOD;
      end
      ST_MOD: begin
        cmd_o.mod_step = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == STEP_W'(MOD_STEPS - 1)) begin
          cnt_d = '0;
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        cmd_o.decide = 1'b1;
        state_d = ST_SEED;
      end
      ST_SEED: begin
        cmd_o.seed_step = 1'b1;
        state_d = ST_MUL;
      end
      ST_MUL: begin
        cmd_o.mul_step = 1'b1;
        state_d = ST_MIX;
      end
      ST_MIX: begin
        cmd_o.mix = 1'b1;
        state_d = ST_HOLD;
      end
      ST_HOLD: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_d = (out_valid_q && !out_ready_i) || cmd_o.out_load;
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot(state_q))
    else $error("controller state not one-hot");
  a_accept_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> state_q == ST_DIV)
    else $error("accepted word did not start the divide");
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || out_ready_i))
    else $error("result overwrote a waiting word");
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MOD) |-> cnt_q < STEP_W'(MOD_STEPS))
    else $error("step count out of range");

endmodule

// ===== rtl/core/mcm_datapath.sv =====
module mcm_datapath #(
  parameter int SAMPLE_RATE = 32000
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mcm_pkg::cfg_t      cfg_i,
  input  logic               cancel_i,
  input  mcm_pkg::in_word_t  in_word_i,
  input  mcm_pkg::dp_cmd_t   cmd_i,
  output mcm_pkg::dp_sts_t   sts_o,
  output mcm_pkg::out_word_t out_word_o
);
  import mcm_pkg::*;

  localparam int ACCENT_LEN = SAMPLE_RATE / 80;
  localparam int BEAT_LEN   = SAMPLE_RATE / 200;
  localparam int CNT_W      = $clog2(ACCENT_LEN + 1);

  // item registers
  logic signed [15:0] left_q, right_q;
  logic               resync_q, neg_q;
  logic [79:0]        dvd_q;
  logic [32:0]        rem_q;
  logic signed [47:0] row_q;
  logic [47:0]        arow_q;
  logic [8:0]         ra_q, rb_q;
  logic               act_q, sign_q;
  logic [47:0]        prod_q;
  out_word_t          res_q, out_q;

  // persistent state
  logic signed [47:0] last_row_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [15:0]        gain_q;
  logic [31:0]        seed_q;

  // load
  logic        idx_neg;
  logic [47:0] mag;
  assign idx_neg = in_word_i.sample_index < cfg_i.ref_sample;
  assign mag = idx_neg ? cfg_i.ref_sample - in_word_i.sample_index
                       : in_word_i.sample_index - cfg_i.ref_sample;

  // restoring divide step
  logic [32:0] rem_sh, spr_x;
  logic        geq;
  assign rem_sh = {rem_q[31:0], dvd_q[79]};
  assign spr_x  = {1'b0, cfg_i.spr};
  assign geq    = rem_sh >= spr_x;

  // row assembly
  logic [63:0]        q;
  logic [48:0]        qc;
  logic [16:0]        c17, fpart, fsum;
  logic               czero;
  logic signed [50:0] pos, ipart, ri, row51;
  logic signed [47:0] row48;
  assign q     = dvd_q[79:16];
  assign qc    = (|q[63:49] || (q[48] && |q[47:0])) ? {1'b1, 48'd0} : q[48:0];
  assign c17   = {1'b0, dvd_q[15:0]} + {16'd0, |rem_q};
  assign czero = c17 == 17'd0;
  assign pos   = {2'b00, qc};
  assign ipart = !neg_q ? pos : (czero ? -pos : -pos - 51'sd1);
  assign fpart = !neg_q ? {1'b0, dvd_q[15:0]} : (czero ? 17'd0 : 17'h10000 - c17);
  assign fsum  = {1'b0, fpart[15:0]} + {1'b0, cfg_i.ref_row[15:0]};
  assign ri    = {{35{cfg_i.ref_row[31]}}, cfg_i.ref_row[31:16]};
  assign row51 = ipart + ri + {50'd0, fsum[16]};
  always_comb begin
    // clamp to the 48-bit signed range
    if (row51[50:47] == 4'b0000 || row51[50:47] == 4'b1111) row48 = row51[47:0];
    else if (row51[50]) row48 = {1'b1, 47'd0};
    else row48 = {1'b0, {47{1'b1}}};
  end

  // modulo steps
  logic [8:0] acc_div, beat_div, ra_sh, rb_sh;
  assign acc_div  = (cfg_i.accent_every == 8'd0) ? 9'd1 : {1'b0, cfg_i.accent_every};
  assign beat_div = (cfg_i.beat_every == 8'd0) ? 9'd1 : {1'b0, cfg_i.beat_every};
  assign ra_sh    = {ra_q[7:0], arow_q[47]};
  assign rb_sh    = {rb_q[7:0], arow_q[47]};

  // noise
  logic [31:0] acc_gain_p, beat_gain_p, decay_p, seed_nx, smag;
  logic [62:0] big;
  logic signed [16:0] n17;
  logic signed [17:0] suml, sumr;
  logic signed [15:0] satl, satr;
  assign acc_gain_p  = cfg_i.volume * ACCENT_K;
  assign beat_gain_p = cfg_i.volume * BEAT_K;
  assign decay_p     = gain_q * DECAY_K;
  assign seed_nx     = seed_q * LCG_MUL + LCG_ADD;
  assign smag        = seed_q[31] ? 32'd0 - seed_q : seed_q;
  assign big         = {prod_q, 15'd0} - {15'd0, prod_q};
  assign n17         = sign_q ? -$signed({1'b0, big[62:47]}) : $signed({1'b0, big[62:47]});
  assign suml        = 18'(left_q) + 18'(n17);
  assign sumr        = 18'(right_q) + 18'(n17);

  function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
    if (v > 18'sd32767) return 16'sh7fff;
    if (v < -18'sd32768) return 16'sh8000;
    return v[15:0];
  endfunction
  assign satl = sat16(suml);
  assign satr = sat16(sumr);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      left_q   <= in_word_i.sample_left;
      right_q  <= in_word_i.sample_right;
      resync_q <= in_word_i.resync;
      neg_q    <= idx_neg;
      dvd_q    <= {mag, 32'd0};
      rem_q    <= '0;
    end
    if (cmd_i.div_step) begin
      rem_q <= geq ? rem_sh - spr_x : rem_sh;
      dvd_q <= {dvd_q[78:0], geq};
    end
    if (cmd_i.row_calc) begin
      row_q  <= row48;
      arow_q <= row48[47] ? 48'd0 - row48 : row48;
      ra_q   <= '0;
      rb_q   <= '0;
    end
    if (cmd_i.mod_step) begin
      ra_q   <= (ra_sh >= acc_div) ? ra_sh - acc_div : ra_sh;
      rb_q   <= (rb_sh >= beat_div) ? rb_sh - beat_div : rb_sh;
      arow_q <= {arow_q[46:0], 1'b0};
    end
    if (cmd_i.mul_step) begin
      prod_q <= smag * gain_q;
      sign_q <= seed_q[31];
    end
    if (cmd_i.mix) begin
      res_q.mixed_left   <= act_q ? satl : left_q;
      res_q.mixed_right  <= act_q ? satr : right_q;
      res_q.click_active <= act_q;
    end
    if (cmd_i.out_load) out_q <= res_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_row_q <= {1'b1, 47'd0};
      cnt_q      <= '0;
      gain_q     <= '0;
      seed_q     <= '0;
      act_q      <= 1'b0;
    end else begin
      if (cmd_i.load) act_q <= 1'b0;
      if (cmd_i.decide) begin
        if (resync_q) begin
          last_row_q <= row_q;
        end else if (cfg_i.enable && row_q > last_row_q) begin
          last_row_q <= row_q;
          if (ra_q == 9'd0) begin
            gain_q <= acc_gain_p[31:16];
            cnt_q  <= CNT_W'(ACCENT_LEN);
          end else if (rb_q == 9'd0) begin
            gain_q <= beat_gain_p[31:16];
            cnt_q  <= CNT_W'(BEAT_LEN);
          end
        end
      end
      if (cmd_i.seed_step) begin
        act_q <= cfg_i.enable && (cnt_q != '0);
        if (cfg_i.enable && (cnt_q != '0)) seed_q <= seed_nx;
      end
      if (cmd_i.mix && act_q) begin
        gain_q <= decay_p[31:16];
        cnt_q  <= cnt_q - 1'b1;
      end
      if (cancel_i) cnt_q <= '0;
    end
  end

  assign sts_o.spr_zero = cfg_i.spr == 32'd0;
  assign out_word_o = out_q;

endmodule

// ===== rtl/core/metronome_click_mixer.sv =====
// Each accepted word goes through 80 divide steps, row assembly, 48 modulo steps and the decide,
// seed, noise multiply and mixing steps; when the tempo is zero it goes straight to mixing.
// A word is taken only while the block is idle, so a new word waits until the previous one is
// through; a result held by the receiver stalls the next word.
// A new word is taken while the previous result waits in the output register.
// Reset (rst_ni low, asynchronous) returns the control, configuration and click state to their
// defaults (not the data registers), sets the last row to the most negative value and stops any click.
module metronome_click_mixer #(
  parameter int SAMPLE_RATE = 32000
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  mcm_stream_if.sink   in_i,
  mcm_stream_if.source out_o,
  mcm_stream_if.sink   cfg_i
);
  import mcm_pkg::*;

  // Configuration registers, to be written only while the block is idle; the block itself does not enforce it
  cfg_t cfg_q;
  logic cancel;
  in_word_t in_word;
  cfg_word_t cfg_word;
  dp_cmd_t cmd;
  dp_sts_t sts;
  out_word_t out_word;

  assign in_word  = in_i.data;
  assign cfg_word = cfg_i.data;

  // Always take configuration words
  assign cfg_i.ready = 1'b1;

  // Drop a running click when the metronome is switched off
  assign cancel = cfg_i.valid && (cfg_word.reg_index == REG_ENABLE) && !cfg_word.wdata[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enable       <= 1'b0;
      cfg_q.spr          <= '0;
      cfg_q.ref_row      <= '0;
      cfg_q.ref_sample   <= '0;
      cfg_q.beat_every   <= 8'd1;
      cfg_q.accent_every <= 8'd4;
      cfg_q.volume       <= 16'hffff;
    end else if (cfg_i.valid) begin
      unique case (cfg_word.reg_index)
        REG_ENABLE:     cfg_q.enable       <= cfg_word.wdata[0];
        REG_SPR:        cfg_q.spr          <= cfg_word.wdata[31:0];
        REG_REF_ROW:    cfg_q.ref_row      <= cfg_word.wdata[31:0];
        REG_REF_SAMPLE: cfg_q.ref_sample   <= cfg_word.wdata;
        REG_BEAT:       cfg_q.beat_every   <= cfg_word.wdata[7:0];
        REG_ACCENT:     cfg_q.accent_every <= cfg_word.wdata[7:0];
        REG_VOLUME:     cfg_q.volume       <= cfg_word.wdata[15:0];
        default: ;  // ignore unknown register indices
      endcase
    end
  end

  // Sequencer: walks each word through divide, modulo, noise and mixing steps (only mixing at zero tempo)
  mcm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Arithmetic, click state and the output register
  mcm_datapath #(
    .SAMPLE_RATE (SAMPLE_RATE)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .cancel_i   (cancel),
    .in_word_i  (in_word),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_word_o (out_word)
  );

  assign out_o.data = out_word;

endmodule
